### rtl/greedy_knapsack_select_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the greedy knapsack selector
// ---------------------------------------------------------------------------
`ifndef GREEDY_KNAPSACK_SELECT_ASSERT_SVH
`define GREEDY_KNAPSACK_SELECT_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define GKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gks check failed");

// Next-cycle implication, clocked on clk, quiet during reset.
`define GKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gks check failed");

`endif

### rtl/gks_pkg.sv
// ---------------------------------------------------------------------------
// gks_pkg
// Shared types for the greedy knapsack selector.
// ---------------------------------------------------------------------------
package gks_pkg;

  localparam int FIELD_BITS = 16;
  localparam int CAP_BITS   = 22;
  localparam int PSUM_BITS  = 21;

  typedef struct packed {
    logic [FIELD_BITS-1:0] weight;
    logic [FIELD_BITS-1:0] profit;
    logic                  last_item;
  } gks_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_ST,
    S_INS_MUL,
    S_INS_CMP,
    S_INS_PUT,
    S_WK_RD,
    S_WK_ST,
    S_WK_EVAL,
    S_SUM
  } gks_state_t;

endpackage

### rtl/gks_front.sv
// ---------------------------------------------------------------------------
// gks_front
// Accepts items, masks values and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module gks_front #(
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [15:0]       weight,
  input  logic [15:0]       profit,
  input  logic              last_item,
  output logic              busy,
  input  logic              pop,
  output logic              avail,
  output gks_pkg::gks_item_t head
);
  import gks_pkg::*;

  localparam int VB = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam logic [FIELD_BITS-1:0] VMASK = FIELD_BITS'((32'd1 << VB) - 32'd1);

  gks_item_t  q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, do_pop;

  assign busy   = (cnt == 2'd2);
  assign avail  = (cnt != 2'd0);
  assign push   = start && !busy;
  assign do_pop = pop && avail;
  assign head   = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{weight: weight & VMASK, profit: profit & VMASK, last_item: last_item};
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push)   wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(do_pop);
    end
  end
endmodule

### rtl/gks_back.sv
// ---------------------------------------------------------------------------
// gks_back
// Ranks stored items by profit/weight ratio and walks the rank list.
// ---------------------------------------------------------------------------
module gks_back #(
  parameter int MAX_ITEMS  = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gks_pkg::CAP_BITS-1:0] capacity,
  input  logic                       avail,
  input  gks_pkg::gks_item_t         head,
  output logic                       pop,
  output logic                       result_valid,
  output logic                       is_summary,
  output logic [4:0]                 item_index,
  output logic [15:0]                item_weight,
  output logic [15:0]                item_profit,
  output logic [gks_pkg::CAP_BITS-1:0] total_weight,
  output logic [gks_pkg::PSUM_BITS-1:0] total_profit,
  output logic                       overflow,
  output logic                       last
);
  import gks_pkg::*;

  localparam int VB = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_ITEMS);
  localparam logic [PSUM_BITS-1:0] PMAX = '1;

  // Item and rank memories
  logic [VB-1:0] st_w [MAX_ITEMS];
  logic [VB-1:0] st_p [MAX_ITEMS];
  logic [IW-1:0] rank_mem [MAX_ITEMS];

  gks_state_t state, state_next;

  logic [CW-1:0]  loaded;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  wi;
  logic [VB-1:0]  wn, pn;
  logic           last_q;
  logic           dropped;
  logic [CAP_BITS-1:0]  wsum;
  logic [PSUM_BITS-1:0] psum;
  logic [IW-1:0]  rank_q;
  logic [IW-1:0]  id_q;
  logic [VB-1:0]  sw_q, sp_q;
  logic [2*VB-1:0] prod_a, prod_b;

  logic          rank_we;
  logic [IW-1:0] rank_wa, rank_wd, rank_ra, st_ra;
  logic          st_we;

  logic [VB-1:0] wa, pa, wb, pb;
  logic [CAP_BITS:0]    wtry;
  logic [PSUM_BITS:0]   ptry;
  logic                 fits;
  logic [PSUM_BITS-1:0] psat;
  logic [5:0]           id_ext;

  assign wa = (wn == '0) ? VB'(1) : wn;
  assign pa = (wn == '0) ? '0 : pn;
  assign wb = (sw_q == '0) ? VB'(1) : sw_q;
  assign pb = (sw_q == '0) ? '0 : sp_q;

  assign wtry   = {1'b0, wsum} + (CAP_BITS + 1)'(sw_q);
  assign ptry   = {1'b0, psum} + (PSUM_BITS + 1)'(sp_q);
  assign fits   = (wtry <= {1'b0, capacity});
  assign psat   = ptry[PSUM_BITS] ? PMAX : ptry[PSUM_BITS-1:0];
  assign id_ext = 6'(id_q);

  assign st_we = (state == S_IDLE) && avail && (loaded < CMAX);

  // Next state and memory controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rank_we    = 1'b0;
    rank_wa    = pos[IW-1:0];
    rank_wd    = loaded[IW-1:0];
    rank_ra    = wi[IW-1:0];
    st_ra      = rank_q;
    unique case (state)
      S_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          if (loaded < CMAX) begin
            if (loaded == '0) begin
              rank_we = 1'b1;
              rank_wa = '0;
              rank_wd = '0;
              state_next = head.last_item ? S_WK_RD : S_IDLE;
            end else begin
              state_next = S_INS_RD;
            end
          end else begin
            state_next = head.last_item ? ((loaded == '0) ? S_SUM : S_WK_RD) : S_IDLE;
          end
        end
      end
      S_INS_RD: begin
        rank_ra    = IW'(pos - CW'(1));
        state_next = S_INS_ST;
      end
      // Keep the rank entry above pos on rank_q until the compare moves it.
      S_INS_ST: begin
        rank_ra    = IW'(pos - CW'(1));
        state_next = S_INS_MUL;
      end
      S_INS_MUL: begin
        rank_ra    = IW'(pos - CW'(1));
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (prod_a > prod_b) begin
          rank_we    = 1'b1;
          rank_wd    = rank_q;
          state_next = (pos == CW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        rank_we    = 1'b1;
        rank_wd    = IW'(loaded - CW'(1));
        state_next = last_q ? S_WK_RD : S_IDLE;
      end
      S_WK_RD:   state_next = S_WK_ST;
      S_WK_ST:   state_next = S_WK_EVAL;
      S_WK_EVAL: state_next = (wi + CW'(1) < loaded) ? S_WK_RD : S_SUM;
      S_SUM:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_w[loaded[IW-1:0]] <= head.weight[VB-1:0];
      st_p[loaded[IW-1:0]] <= head.profit[VB-1:0];
    end
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_q <= rank_mem[rank_ra];
    sw_q   <= st_w[st_ra];
    sp_q   <= st_p[st_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_a <= pa * wb;
    prod_b <= pb * wa;
    if (state == S_WK_ST) id_q <= rank_q;
    if (rst) begin
      loaded       <= '0;
      dropped      <= 1'b0;
      wsum         <= '0;
      psum         <= '0;
      result_valid <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          wi   <= '0;
          wsum <= '0;
          psum <= '0;
          if (avail) begin
            last_q <= head.last_item;
            if (loaded < CMAX) begin
              wn     <= head.weight[VB-1:0];
              pn     <= head.profit[VB-1:0];
              pos    <= loaded;
              loaded <= loaded + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_INS_CMP: begin
          if (prod_a > prod_b) pos <= pos - CW'(1);
        end
        S_WK_EVAL: begin
          wi <= wi + CW'(1);
          if (fits) begin
            wsum         <= wtry[CAP_BITS-1:0];
            psum         <= psat;
            result_valid <= 1'b1;
            is_summary   <= 1'b0;
            item_index   <= id_ext[4:0];
            item_weight  <= 16'(sw_q);
            item_profit  <= 16'(sp_q);
            total_weight <= wtry[CAP_BITS-1:0];
            total_profit <= psat;
            overflow     <= 1'b0;
            last         <= 1'b0;
          end
        end
        S_SUM: begin
          result_valid <= 1'b1;
          is_summary   <= 1'b1;
          item_index   <= '0;
          item_weight  <= '0;
          item_profit  <= '0;
          total_weight <= wsum;
          total_profit <= psum;
          overflow     <= dropped;
          last         <= 1'b1;
          loaded       <= '0;
          dropped      <= 1'b0;
          wsum         <= '0;
          psum         <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/greedy_knapsack_select.sv
// ---------------------------------------------------------------------------
// greedy_knapsack_select
// Greedy 0/1 knapsack selection by profit-to-weight ratio.
// ---------------------------------------------------------------------------
// Usage:
//   Set capacity through cfg_we/cfg_wdata while the block is idle.
//   Present an item (weight, profit, last_item) with start; the transfer
//   happens on an edge where start is high and busy is low. A two-entry
//   queue parts intake from the ranking engine, so items are taken while
//   the engine works until the queue fills.
//   The engine inserts item k into the rank list with one compare per
//   entry it checks; each compare steps through the read, settle, multiply
//   and compare states, due to the registered reads of the rank and item
//   memories and the registered cross-multiply.
//   On the item flagged last_item the rank list is walked, each stored
//   item through the read, settle and evaluate states; each item that
//   fits gives one record on result_valid, followed by a summary record
//   (is_summary=1, last=1). Records last one cycle and cannot be stalled.
//   Reset clears the count, sums, drop flag, queue and capacity; the item
//   and rank memories need no clearing.
// ---------------------------------------------------------------------------
module greedy_knapsack_select #(
  parameter int MAX_ITEMS  = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [21:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] weight,
  input  logic [15:0] profit,
  input  logic        last_item,
  output logic        result_valid,
  output logic        is_summary,
  output logic [4:0]  item_index,
  output logic [15:0] item_weight,
  output logic [15:0] item_profit,
  output logic [21:0] total_weight,
  output logic [20:0] total_profit,
  output logic        overflow,
  output logic        last
);
  import gks_pkg::*;

  logic [CAP_BITS-1:0] capacity;
  logic                avail, pop;
  gks_item_t           head;

  // Hold the capacity register; the user must write it only between runs, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst)         capacity <= '0;
    else if (cfg_we) capacity <= cfg_wdata;
  end

  gks_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .weight(weight), .profit(profit),
    .last_item(last_item), .busy(busy), .pop(pop), .avail(avail), .head(head)
  );

  gks_back #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst(rst), .capacity(capacity), .avail(avail), .head(head),
    .pop(pop), .result_valid(result_valid), .is_summary(is_summary),
    .item_index(item_index), .item_weight(item_weight),
    .item_profit(item_profit), .total_weight(total_weight),
    .total_profit(total_profit), .overflow(overflow), .last(last)
  );

`include "greedy_knapsack_select_assert.svh"

  // Item records never carry the overflow or last marks.
  `GKS_ASSERT_NOW(a_item_marks, result_valid && !is_summary, !overflow && !last)
  // Selected weight never exceeds the capacity.
  `GKS_ASSERT_NOW(a_cap, result_valid, total_weight <= capacity)
  // A summary ends the run: no record follows directly.
  `GKS_ASSERT_NEXT(a_sum_gap, result_valid && is_summary, !result_valid)

endmodule

### tb/tb_greedy_knapsack_select.sv
// ---------------------------------------------------------------------------
// tb_greedy_knapsack_select
// Self-checking bench for the greedy knapsack selector. A table of short item
// sets runs first, then random sets under several capacities. Every record
// the block emits is checked against an in-bench ratio-ordered selector.
// ---------------------------------------------------------------------------
module tb_greedy_knapsack_select;

  localparam int STORE_DEPTH = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 200;  // walk of a full store plus margin
  localparam logic [21:0] CAP_FULL = 22'h3FFFFF;

  typedef struct packed {
    logic        summ;
    logic [4:0]  idx;
    logic [15:0] w;
    logic [15:0] p;
    logic [21:0] tw;
    logic [20:0] tp;
    logic        ov;
    logic        lst;
  } record_t;

  // One directed row: optional capacity write ahead of it, the item, and a
  // typed summary where it can be read off directly.
  typedef struct {
    bit          wr_cap;
    logic [21:0] cap;
    logic [15:0] w;
    logic [15:0] p;
    bit          lst;
    bit          typed;
    logic [21:0] tw;
    logic [20:0] tp;
    bit          ov;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [21:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] weight = '0;
  logic [15:0] profit = '0;
  logic        last_item = 1'b0;
  logic        result_valid;
  logic        is_summary;
  logic [4:0]  item_index;
  logic [15:0] item_weight;
  logic [15:0] item_profit;
  logic [21:0] total_weight;
  logic [20:0] total_profit;
  logic        overflow;
  logic        last;

  greedy_knapsack_select dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .weight(weight), .profit(profit),
    .last_item(last_item), .result_valid(result_valid),
    .is_summary(is_summary), .item_index(item_index),
    .item_weight(item_weight), .item_profit(item_profit),
    .total_weight(total_weight), .total_profit(total_profit),
    .overflow(overflow), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Selector state mirrored in the bench.
  logic [15:0] held_w [STORE_DEPTH];
  logic [15:0] held_p [STORE_DEPTH];
  int          ratio_rank [STORE_DEPTH];
  int          held_count = 0;
  bit          lost_items = 1'b0;
  logic [21:0] knap_cap = '0;

  record_t pending_records [$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      sent_count = 0;
  bit      quiet_run = 1'b0;  // long stretch with no sender gaps

  row_t rows [$];

  // Append one expected record behind the ones already waiting.
  function automatic void queue_record(record_t r);
    pending_records.insert(pending_records.size(), r);
  endfunction

  // Append one directed row to the table.
  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // Strictly better ratio of stored item a over b; zero weight is ratio zero.
  function automatic bit better_ratio(int a, int b);
    longint unsigned pa, wa, pb, wb;
    pa = held_p[a]; wa = held_w[a];
    pb = held_p[b]; wb = held_w[b];
    if (wa == 0) begin pa = 0; wa = 1; end
    if (wb == 0) begin pb = 0; wb = 1; end
    return pa * wb > pb * wa;
  endfunction

  // Rank the new item, and on the set's last item walk the ranking and queue
  // one record per item taken plus the summary.
  task automatic absorb_item(logic [15:0] w, logic [15:0] p, bit lst);
    int pos;
    int id;
    longint unsigned wsum, psum;
    if (held_count < STORE_DEPTH) begin
      held_w[held_count] = w;
      held_p[held_count] = p;
      pos = held_count;
      while (pos > 0 && better_ratio(held_count, ratio_rank[pos-1])) begin
        ratio_rank[pos] = ratio_rank[pos-1];
        pos--;
      end
      ratio_rank[pos] = held_count;
      held_count++;
    end else begin
      lost_items = 1'b1;
    end
    if (!lst) return;
    wsum = 0;
    psum = 0;
    for (int i = 0; i < held_count; i++) begin
      id = ratio_rank[i];
      if (wsum + held_w[id] <= knap_cap) begin
        wsum += held_w[id];
        psum += held_p[id];
        if (psum > 21'h1FFFFF) psum = 21'h1FFFFF;
        queue_record('{1'b0, id[4:0], held_w[id], held_p[id],
                       wsum[21:0], psum[20:0], 1'b0, 1'b0});
      end
    end
    queue_record('{1'b1, 5'd0, 16'd0, 16'd0, wsum[21:0],
                   psum[20:0], lost_items, 1'b1});
    held_count = 0;
    lost_items = 1'b0;
  endtask

  // Present one item from a falling edge; hold start high after the transfer
  // so back-to-back items need no extra edge on it.
  task automatic send_item(logic [15:0] w, logic [15:0] p, bit lst);
    if (!quiet_run && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start <= 1'b1;
    weight <= w;
    profit <= p;
    last_item <= lst;
    do @(posedge clk); while (busy);
    absorb_item(w, p, lst);
    sent_count++;
    @(negedge clk);
  endtask

  // Drain everything in flight, then let the engine settle before touching
  // the capacity register.
  task automatic write_capacity(logic [21:0] value);
    start <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    knap_cap = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Check every record against the oldest pending one.
  always @(posedge clk) begin
    record_t got;
    record_t want;
    if (!rst && result_valid) begin
      got = '{is_summary, item_index, item_weight, item_profit, total_weight,
              total_profit, overflow, last};
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, actual %p", $time, got);
        fail_count++;
      end else begin
        want = pending_records.pop_front();
        if (got.summ !== want.summ || got.idx !== want.idx || got.w !== want.w
            || got.p !== want.p || got.tw !== want.tw || got.tp !== want.tp
            || got.ov !== want.ov || got.lst !== want.lst) begin
          $display("%0t: record mismatch, expected %p actual %p",
                   $time, want, got);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int set_len;
    int wmode;
    logic [15:0] rw, rp;
    logic [21:0] rcap;

    // Capacity zero after reset: nothing fits except zero-weight items.
    add_row('{0, 0, 16'd5, 16'd7, 1, 1, 22'd0, 21'd0, 0});
    add_row('{0, 0, 16'd0, 16'hFFFF, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'hFFFF, 16'hFFFF, 1, 1, 22'd0, 21'd65535, 0});
    // Full capacity: everything fits; ties and zero weight in the ranking.
    add_row('{1, CAP_FULL, 16'hFFFF, 16'd0, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd1, 16'hFFFF, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd2, 16'd4, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd1, 16'd2, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd0, 16'd0, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0});
    add_row('{0, 0, 16'hAAAA, 16'h5555, 1, 1, 22'h00AAAA, 21'h5555, 0});
    add_row('{0, 0, 16'h5555, 16'hAAAA, 1, 1, 22'h005555, 21'hAAAA, 0});
    // Tight capacity: greedy skips what no longer fits.
    add_row('{1, 22'd1, 16'd1, 16'd1, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd1, 16'd5, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd2, 16'hFFFF, 1, 0, 0, 0, 0});
    add_row('{1, 22'd65535, 16'hFFFF, 16'd1, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd30000, 16'd30000, 0, 0, 0, 0, 0});
    add_row('{0, 0, 16'd35535, 16'd40000, 1, 0, 0, 0, 0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].wr_cap) write_capacity(rows[i].cap);
      send_item(rows[i].w, rows[i].p, rows[i].lst);
      // Typed summaries stand in for the predicted one.
      if (rows[i].typed)
        pending_records[pending_records.size()-1] =
          '{1'b1, 5'd0, 16'd0, 16'd0, rows[i].tw, rows[i].tp, rows[i].ov, 1'b1};
    end

    // Random sets, capacity changed between phases.
    while (sent_count < 170) begin
      if ($urandom_range(0, 3) == 0 || sent_count < 20) begin
        case ($urandom_range(0, 4))
          0: rcap = 22'($urandom_range(0, 300));
          1: rcap = 22'd65535;
          2: rcap = CAP_FULL;
          3: rcap = 22'($urandom_range(0, 200000));
          default: rcap = 22'($urandom()) & CAP_FULL;
        endcase
        write_capacity(rcap);
      end
      quiet_run = (sent_count > 60 && sent_count < 120);
      // Mostly short sets; now and then a set that overfills the store.
      if ($urandom_range(0, 11) == 0) set_len = $urandom_range(STORE_DEPTH + 1,
                                                               STORE_DEPTH + 4);
      else set_len = $urandom_range(1, 8);
      wmode = $urandom_range(0, 2);
      for (int k = 0; k < set_len; k++) begin
        if ($urandom_range(0, 9) == 0) rw = 16'd0;
        else if (wmode == 0) rw = 16'($urandom_range(0, 255));
        else rw = 16'($urandom());
        rp = ($urandom_range(0, 1)) ? 16'($urandom()) : 16'($urandom_range(0, 255));
        send_item(rw, rp, k == set_len - 1);
      end
    end

    start <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
